// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge out of reset
`define PM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// expression must never be true
`define PM_ASSERT_NEVER(label, expr, msg) \
	`PM_ASSERT(label, !(expr), msg)

`endif

// ===== design/pmono_pkg.sv =====
// ----------------------------------------------------------------------------
// pmono_pkg
// types and constants shared by the pcm frame to mono16 mixer
// ----------------------------------------------------------------------------
package pmono_pkg;

	localparam int BYTE_W       = 8;
	localparam int BITS_W       = 6;
	localparam int CHAN_W       = 4;
	localparam int PAD_W        = 4;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 6;
	localparam int SAMPLE_W     = 32;
	localparam int TOTAL_W      = 35;
	localparam int SCALED_W     = 51;
	localparam int MONO_W       = 16;
	localparam int MAX_CHANNELS = 8;
	localparam int QUEUE_DEPTH  = 2;

	// quotient bits per cycle in the divider and its step count
	localparam int DIV_RADIX_BITS = 4;
	localparam int DIV_W          = 52;
	localparam int DIV_STEPS      = DIV_W / DIV_RADIX_BITS;

	localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_SAMPLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_BYTES       = 2'd2;

	typedef struct packed {
		logic [BITS_W-1:0] bits_per_sample;
		logic [CHAN_W-1:0] channel_count;
		logic [PAD_W-1:0]  pad_bytes;
	} cfg_t;

	// one finished frame, or a stream end inside a frame
	typedef struct packed {
		logic signed [TOTAL_W-1:0] total;
		logic [BITS_W-1:0]         bits;
		logic [CHAN_W-1:0]         chans;
		logic                      truncated;
	} job_t;

endpackage

// ===== design/pmono_queue.sv =====
// ----------------------------------------------------------------------------
// pmono_queue
// short job queue between the byte parser and the mixing back end
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pmono_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pmono_pkg::job_t push_job,
	output logic            full,
	input  logic            pop,
	output pmono_pkg::job_t pop_job,
	output logic            empty
);
	import pmono_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`PM_ASSERT_NEVER(a_push_full, push && full, "job pushed into a full queue")
	`PM_ASSERT_NEVER(a_pop_empty, pop && empty, "job popped from an empty queue")

endmodule

// ===== design/pmono_front.sv =====
// ----------------------------------------------------------------------------
// pmono_front
// byte parser: drops pad bytes, gathers and decodes channel samples and
// sums them into a frame total that is handed to the queue
// ----------------------------------------------------------------------------
module pmono_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pmono_pkg::cfg_t              cfg,
	input  logic                         byte_valid,
	output logic                         byte_ready,
	input  logic [pmono_pkg::BYTE_W-1:0] byte_data,
	input  logic                         byte_end,
	input  logic                         queue_full,
	output logic                         push,
	output pmono_pkg::job_t              push_job
);
	import pmono_pkg::*;

	logic [PAD_W-1:0]           pad_q;
	logic [1:0]                 bpos_q;
	logic [2:0]                 chan_q;
	logic [SAMPLE_W-1:0]        gath_q;
	logic signed [TOTAL_W-1:0]  total_q;

	logic [BITS_W-1:0]          eff_bits;
	logic [CHAN_W-1:0]          eff_chans;
	logic [BITS_W-1:0]          bits_plus;
	logic [2:0]                 nbytes;
	logic [2:0]                 got;
	logic [2:0]                 chan_next;
	logic [SAMPLE_W-1:0]        gath_new;
	logic signed [SAMPLE_W-1:0] aligned;
	logic signed [SAMPLE_W-1:0] sample;
	logic signed [TOTAL_W-1:0]  total_new;
	logic                       accept;
	logic                       mid;
	logic                       pad_step;
	logic                       sample_done;
	logic                       frame_done;

	always_comb begin
		if (cfg.bits_per_sample == '0) begin
			eff_bits = BITS_W'(1);
		end else if (cfg.bits_per_sample > BITS_W'(SAMPLE_W)) begin
			eff_bits = BITS_W'(SAMPLE_W);
		end else begin
			eff_bits = cfg.bits_per_sample;
		end
		if (cfg.channel_count == '0) begin
			eff_chans = CHAN_W'(1);
		end else if (cfg.channel_count > CHAN_W'(MAX_CHANNELS)) begin
			eff_chans = CHAN_W'(MAX_CHANNELS);
		end else begin
			eff_chans = cfg.channel_count;
		end
	end

	assign bits_plus = eff_bits + BITS_W'(7);
	assign nbytes    = bits_plus[5:3];
	assign got       = {1'b0, bpos_q} + 3'd1;
	assign chan_next = chan_q + 3'd1;

	// left-align the gathered bytes so the sample sits in the top bits
	always_comb begin
		gath_new = gath_q | (SAMPLE_W'(byte_data) << {bpos_q, 3'b000});
		aligned  = gath_new << {~bpos_q, 3'b000};
		if (eff_bits <= BITS_W'(8)) begin
			aligned[SAMPLE_W-1] = ~aligned[SAMPLE_W-1];
		end
		sample    = aligned >>> 5'(BITS_W'(SAMPLE_W) - eff_bits);
		total_new = total_q + {{(TOTAL_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
	end

	assign byte_ready  = !queue_full;
	assign accept      = byte_valid && byte_ready;
	assign mid         = (pad_q != '0) || (bpos_q != '0) || (chan_q != '0);
	assign pad_step    = (bpos_q == '0) && (pad_q < cfg.pad_bytes);
	assign sample_done = !pad_step && (got >= nbytes);
	assign frame_done  = sample_done &&
		((chan_next == '0) || ({1'b0, chan_next} >= eff_chans));

	always_comb begin
		push_job.total     = byte_end ? '0 : total_new;
		push_job.bits      = eff_bits;
		push_job.chans     = eff_chans;
		push_job.truncated = byte_end;
		push = accept && (byte_end ? mid : frame_done);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q   <= '0;
			bpos_q  <= '0;
			chan_q  <= '0;
			gath_q  <= '0;
			total_q <= '0;
		end else if (accept) begin
			if (byte_end) begin
				pad_q   <= '0;
				bpos_q  <= '0;
				chan_q  <= '0;
				gath_q  <= '0;
				total_q <= '0;
			end else if (pad_step) begin
				pad_q <= pad_q + 1'b1;
			end else if (!sample_done) begin
				gath_q <= gath_new;
				bpos_q <= got[1:0];
			end else begin
				pad_q  <= '0;
				bpos_q <= '0;
				gath_q <= '0;
				if (frame_done) begin
					chan_q  <= '0;
					total_q <= '0;
				end else begin
					chan_q  <= chan_next;
					total_q <= total_new;
				end
			end
		end
	end

endmodule

// ===== design/pmono_back.sv =====
// ----------------------------------------------------------------------------
// pmono_back
// mixing back end: scales a frame total to 16 bits, divides it by the
// channel count four quotient bits a cycle and holds the result for output
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pmono_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                job_empty,
	output logic                                pop,
	input  pmono_pkg::job_t                     job,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [pmono_pkg::MONO_W-1:0] out_sample,
	output logic                                out_truncated
);
	import pmono_pkg::*;

	localparam int STEP_W = $clog2(DIV_STEPS);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCALE = 5'b00010,
		ST_ABS   = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_FIN   = 5'b10000
	} back_state_t;

	back_state_t                state_q;
	job_t                       job_q;
	logic signed [SCALED_W-1:0] scaled_q;
	logic                       neg_q;
	logic [DIV_W-1:0]           work_q;
	logic [2:0]                 rem_q;
	logic [STEP_W-1:0]          step_q;
	logic                       out_valid_q;
	logic signed [MONO_W-1:0]   out_sample_q;
	logic                       out_trunc_q;

	logic signed [SCALED_W-1:0] total_ext;
	logic signed [SCALED_W-1:0] scaled_d;
	logic [SCALED_W-1:0]        mag;
	logic [DIV_W-1:0]           work_d;
	logic [2:0]                 rem_d;
	logic [3:0]                 trial;
	logic [MONO_W-1:0]          quot;
	logic                       out_free;

	assign pop      = (state_q == ST_IDLE) && !job_empty;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		total_ext = {{(SCALED_W-TOTAL_W){job_q.total[TOTAL_W-1]}}, job_q.total};
		if (job_q.bits < BITS_W'(MONO_W)) begin
			scaled_d = total_ext <<< 5'(BITS_W'(MONO_W) - job_q.bits);
		end else begin
			scaled_d = total_ext >>> 5'(job_q.bits - BITS_W'(MONO_W));
		end
		mag = scaled_q[SCALED_W-1] ? (~scaled_q + 1'b1) : scaled_q;
	end

	// restoring division, remainder stays below the channel count
	always_comb begin
		work_d = work_q;
		rem_d  = rem_q;
		trial  = '0;
		for (int i = 0; i < DIV_RADIX_BITS; i++) begin
			trial  = {rem_d, work_d[DIV_W-1]};
			work_d = {work_d[DIV_W-2:0], 1'b0};
			if (trial >= job_q.chans) begin
				rem_d     = 3'(trial - job_q.chans);
				work_d[0] = 1'b1;
			end else begin
				rem_d = trial[2:0];
			end
		end
	end

	assign quot = neg_q ? (~work_q[MONO_W-1:0] + 1'b1) : work_q[MONO_W-1:0];

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					job_q <= job;
				end
			end
			ST_SCALE: begin
				scaled_q <= scaled_d;
			end
			ST_ABS: begin
				neg_q  <= scaled_q[SCALED_W-1];
				work_q <= {1'b0, mag};
				rem_q  <= '0;
			end
			ST_DIV: begin
				work_q <= work_d;
				rem_q  <= rem_d;
			end
			ST_FIN: begin
				if (out_free) begin
					out_sample_q <= job_q.truncated ? '0 : quot;
					out_trunc_q  <= job_q.truncated;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= job.truncated ? ST_FIN : ST_SCALE;
					end
				end
				ST_SCALE: begin
					state_q <= ST_ABS;
				end
				ST_ABS: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign out_sample    = out_sample_q;
	assign out_truncated = out_trunc_q;

	`PM_ASSERT(a_div_runs, (state_q == ST_DIV) && (step_q != STEP_LAST) |=> state_q == ST_DIV, "divider left early")
	`PM_ASSERT(a_fin_holds, (state_q == ST_FIN) && out_valid_q && !out_ready |=> state_q == ST_FIN, "result overwritten while stalled")
	`PM_ASSERT(a_trunc_zero, out_valid_q && out_trunc_q |-> out_sample_q == '0, "truncated result carries a sample")

endmodule

// ===== design/pcm_frame_to_mono16.sv =====
// ----------------------------------------------------------------------------
// pcm_frame_to_mono16
// mixes interleaved raw pcm bytes down to one signed 16-bit mono sample
// per frame
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one raw data byte per transaction; s_tlast marks the end of
//   the stream and its byte is ignored. m_* carries one mixed sample per
//   completed frame; m_tuser is set, with a zero sample, when the stream
//   ended inside a frame. cfg_* writes bits_per_sample (0), channel_count (1)
//   and pad_bytes (2); the user must write them only while the block is idle,
//   as the block itself does not enforce this; cfg_ready is always high.
//   the byte parser takes one byte per cycle while the queue is not full.
//   each frame then passes through the mixer (load, scale, magnitude, 13
//   radix-16 divide steps, result); a truncated job skips to the result. a
//   two-entry queue between parser and mixer lets the parser run ahead.
//   when m_tready is low the result is held, the mixer waits, and s_tready
//   drops once the queue is full. reset clears the frame state and loads
//   16 bits, one channel and no padding.
// ----------------------------------------------------------------------------
module pcm_frame_to_mono16 (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [pmono_pkg::BYTE_W-1:0]         s_tdata,   // [7:0] byte_value
	input  logic                                 s_tlast,   // end_of_data
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic signed [pmono_pkg::MONO_W-1:0]  m_tdata,   // [15:0] mono_sample
	output logic                                 m_tuser,   // [0] truncated
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pmono_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pmono_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import pmono_pkg::*;

	cfg_t cfg_q;
	logic push;
	job_t push_job;
	logic queue_full;
	logic queue_empty;
	logic pop;
	job_t pop_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bits_per_sample <= BITS_W'(16);
			cfg_q.channel_count   <= CHAN_W'(1);
			cfg_q.pad_bytes       <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BITS_PER_SAMPLE: cfg_q.bits_per_sample <= cfg_data;
				REG_CHANNEL_COUNT:   cfg_q.channel_count   <= cfg_data[CHAN_W-1:0];
				REG_PAD_BYTES:       cfg_q.pad_bytes       <= cfg_data[PAD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	pmono_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.byte_valid (s_tvalid),
		.byte_ready (s_tready),
		.byte_data  (s_tdata),
		.byte_end   (s_tlast),
		.queue_full (queue_full),
		.push       (push),
		.push_job   (push_job)
	);

	pmono_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (queue_full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (queue_empty)
	);

	pmono_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_empty     (queue_empty),
		.pop           (pop),
		.job           (pop_job),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_sample    (m_tdata),
		.out_truncated (m_tuser)
	);

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the pcm frame to mono16 mixer: a directed table of
// bytes, stream ends and register writes, then random frames under several
// settings, every transaction on the result side compared with the table's typed
// result where a row gives one, else with a local decoder of the byte stream
// ----------------------------------------------------------------------------
module tb;

	import pmono_pkg::*;

	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 3000;
	localparam int ITEM_TARGET  = 750;
	localparam int FILL_FRAMES  = 60;

	typedef struct packed {
		logic signed [MONO_W-1:0] sample;
		logic                     truncated;
	} mono_result_t;

	typedef enum {ROW_BYTE, ROW_END, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t      kind;
		logic [1:0]     idx;
		logic [7:0]     value;
		bit             typed;
		mono_result_t   res;
	} stim_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [BYTE_W-1:0]        s_tdata = '0;
	logic                     s_tlast = 1'b0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic signed [MONO_W-1:0] m_tdata;
	logic                     m_tuser;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;

	pcm_frame_to_mono16 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// decoder copy of the configuration and frame state
	logic [BITS_W-1:0] cfg_bits = 6'd16;
	logic [CHAN_W-1:0] cfg_chans = 4'd1;
	logic [PAD_W-1:0]  cfg_pad = 4'd0;
	logic [3:0]        pad_seen = '0;
	logic [1:0]        byte_idx = '0;
	logic [2:0]        chan_idx = '0;
	logic [31:0]       sample_acc = '0;
	longint            frame_sum = 0;

	mono_result_t mono_expected[$];
	stim_row_t    stim_rows[$];
	mono_result_t want;
	int           fails = 0;
	int           results_seen = 0;
	int           sent_items = 0;
	int           stall_count = 0;
	bit           no_idle = 1'b0;
	bit           hold_req = 1'b0;

	function automatic int eff_bits();
		if (cfg_bits == 0)
			return 1;
		if (cfg_bits > 32)
			return 32;
		return int'(cfg_bits);
	endfunction

	function automatic int eff_chans();
		if (cfg_chans == 0)
			return 1;
		if (cfg_chans > MAX_CHANNELS)
			return MAX_CHANNELS;
		return int'(cfg_chans);
	endfunction

	task automatic clear_frame_state();
		pad_seen   = '0;
		byte_idx   = '0;
		chan_idx   = '0;
		sample_acc = '0;
		frame_sum  = 0;
	endtask

	task automatic decode_byte(input logic [7:0] data, input logic eod, output bit produced,
			output mono_result_t res);
		int          bits;
		int          chans;
		int          nbytes;
		int          got;
		logic [63:0] v;
		longint      s;
		bits     = eff_bits();
		chans    = eff_chans();
		nbytes   = (bits + 7) / 8;
		produced = 1'b0;
		res      = '0;
		if (eod) begin
			produced = (pad_seen != 0 || byte_idx != 0 || chan_idx != 0);
			res.truncated = produced;
			clear_frame_state();
			return;
		end
		if (byte_idx == 0 && pad_seen < cfg_pad) begin
			pad_seen = pad_seen + 1'b1;
			return;
		end
		sample_acc = sample_acc | (32'(data) << (8 * byte_idx));
		got = int'(byte_idx) + 1;
		if (got < nbytes) begin
			byte_idx = got[1:0];
			return;
		end
		v = {32'd0, sample_acc};
		if (8 * got > bits)
			v = v >> (8 * got - bits);
		if (bits < 32)
			v = v & ((64'd1 << bits) - 64'd1);
		if (bits <= 8) begin
			s = longint'(v) - longint'(64'd1 << (bits - 1));
		end else begin
			s = longint'(v);
			if (v[bits-1])
				s = s - longint'(64'd1 << bits);
		end
		frame_sum  = frame_sum + s;
		pad_seen   = '0;
		byte_idx   = '0;
		sample_acc = '0;
		chan_idx   = chan_idx + 3'd1;
		if (chan_idx != 0 && chan_idx < chans)
			return;
		s = frame_sum;
		if (bits < 16)
			s = s * (longint'(1) << (16 - bits));
		else if (bits > 16)
			s = s >>> (bits - 16);
		s = s / longint'(chans);
		clear_frame_state();
		produced      = 1'b1;
		res.sample    = s[15:0];
		res.truncated = 1'b0;
	endtask

	task automatic send_item(input logic [7:0] data, input logic eod, input bit typed,
			input mono_result_t typed_res);
		bit           produced;
		mono_result_t res;
		while (!no_idle && $urandom_range(0, 99) < 23) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tlast  <= eod;
		do
			@(posedge clk);
		while (!s_tready);
		sent_items++;
		decode_byte(data, eod, produced, res);
		if (typed)
			res = typed_res;
		if (produced)
			mono_expected.push_back(res);
	endtask

	// stop offering, let every expected result arrive, then let the mixer settle
	task automatic wait_quiet();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (mono_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_BITS_PER_SAMPLE: cfg_bits  = data;
			REG_CHANNEL_COUNT:   cfg_chans = data[CHAN_W-1:0];
			REG_PAD_BYTES:       cfg_pad   = data[PAD_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_row(input row_kind_t kind, input logic [1:0] idx, input logic [7:0] value,
			input bit typed, input logic signed [15:0] sample, input logic trunc);
		stim_row_t row;
		row.kind          = kind;
		row.idx           = idx;
		row.value         = value;
		row.typed         = typed;
		row.res.sample    = sample;
		row.res.truncated = trunc;
		stim_rows.push_back(row);
	endtask

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			3: return 8'h7F;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				m_tready <= (no_idle || $urandom_range(0, 99) >= 23);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (mono_expected.size() == 0) begin
				$display("%0t: unexpected result, actual sample %0d truncated %0b",
					$time, m_tdata, m_tuser);
				fails++;
			end else begin
				want = mono_expected.pop_front();
				if (m_tdata !== want.sample || m_tuser !== want.truncated) begin
					$display("%0t: expected sample %0d truncated %0b, actual sample %0d truncated %0b",
						$time, want.sample, want.truncated, m_tdata, m_tuser);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			stall_count <= 0;
		end else if (stall_count >= STALL_LIMIT) begin
			$display("tb failed");
			$finish;
		end else begin
			stall_count <= stall_count + 1;
		end
	end

	initial begin
		int            n_frames;
		int            frame_len;
		int            kind;
		int            cut;
		int            phase;
		logic [3:0]    pick;
		mono_result_t  none;

		none = '0;

		// reset settings: 16 bits, one channel, no padding
		add_row(ROW_BYTE, 2'd0, 8'h00, 1'b0, 16'sd0, 1'b0);
		add_row(ROW_BYTE, 2'd0, 8'h80, 1'b1, -16'sd32768, 1'b0);
		add_row(ROW_BYTE, 2'd0, 8'hFF, 1'b0, 16'sd0, 1'b0);
		add_row(ROW_BYTE, 2'd0, 8'h7F, 1'b1, 16'sd32767, 1'b0);
		// end at a frame boundary, then end inside a frame
		add_row(ROW_END,  2'd0, 8'hC3, 1'b0, 16'sd0, 1'b0);
		add_row(ROW_BYTE, 2'd0, 8'h34, 1'b0, 16'sd0, 1'b0);
		add_row(ROW_END,  2'd0, 8'h5A, 1'b1, 16'sd0, 1'b1);
		// unsigned 8-bit samples
		add_row(ROW_CFG,  REG_BITS_PER_SAMPLE, 8'd8, 1'b0, 16'sd0, 1'b0);
		add_row(ROW_BYTE, 2'd0, 8'h00, 1'b1, -16'sd32768, 1'b0);
		add_row(ROW_BYTE, 2'd0, 8'hFF, 1'b1, 16'sd32512, 1'b0);
		// bits above 32 act as 32
		add_row(ROW_CFG,  REG_BITS_PER_SAMPLE, 8'd63, 1'b0, 16'sd0, 1'b0);
		add_row(ROW_BYTE, 2'd0, 8'h00, 1'b0, 16'sd0, 1'b0);
		add_row(ROW_BYTE, 2'd0, 8'h00, 1'b0, 16'sd0, 1'b0);
		add_row(ROW_BYTE, 2'd0, 8'h00, 1'b0, 16'sd0, 1'b0);
		add_row(ROW_BYTE, 2'd0, 8'h80, 1'b1, -16'sd32768, 1'b0);
		// zero bits and zero channels act as one
		add_row(ROW_CFG,  REG_BITS_PER_SAMPLE, 8'd0, 1'b0, 16'sd0, 1'b0);
		add_row(ROW_CFG,  REG_CHANNEL_COUNT, 8'd0, 1'b0, 16'sd0, 1'b0);
		add_row(ROW_BYTE, 2'd0, 8'h00, 1'b1, -16'sd32768, 1'b0);
		// channels above the maximum act as the maximum
		add_row(ROW_CFG,  REG_BITS_PER_SAMPLE, 8'd1, 1'b0, 16'sd0, 1'b0);
		add_row(ROW_CFG,  REG_CHANNEL_COUNT, 8'd9, 1'b0, 16'sd0, 1'b0);
		for (int i = 0; i < MAX_CHANNELS; i++)
			add_row(ROW_BYTE, 2'd0, (i % 3 == 0) ? 8'h80 : 8'h00, 1'b0, 16'sd0, 1'b0);
		// padding, and a channel count change in the middle of a frame
		add_row(ROW_CFG,  REG_BITS_PER_SAMPLE, 8'd16, 1'b0, 16'sd0, 1'b0);
		add_row(ROW_CFG,  REG_CHANNEL_COUNT, 8'd2, 1'b0, 16'sd0, 1'b0);
		add_row(ROW_CFG,  REG_PAD_BYTES, 8'd1, 1'b0, 16'sd0, 1'b0);
		add_row(ROW_BYTE, 2'd0, 8'hEE, 1'b0, 16'sd0, 1'b0);
		add_row(ROW_BYTE, 2'd0, 8'h21, 1'b0, 16'sd0, 1'b0);
		add_row(ROW_BYTE, 2'd0, 8'hC0, 1'b0, 16'sd0, 1'b0);
		add_row(ROW_CFG,  REG_CHANNEL_COUNT, 8'd1, 1'b0, 16'sd0, 1'b0);
		add_row(ROW_BYTE, 2'd0, 8'h11, 1'b0, 16'sd0, 1'b0);
		add_row(ROW_BYTE, 2'd0, 8'hFF, 1'b0, 16'sd0, 1'b0);
		add_row(ROW_BYTE, 2'd0, 8'h3F, 1'b0, 16'sd0, 1'b0);

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		foreach (stim_rows[i]) begin
			case (stim_rows[i].kind)
				ROW_CFG: begin
					wait_quiet();
					write_reg(stim_rows[i].idx, stim_rows[i].value[CFG_DATA_W-1:0]);
				end
				ROW_END:  send_item(stim_rows[i].value, 1'b1, stim_rows[i].typed, stim_rows[i].res);
				default:  send_item(stim_rows[i].value, 1'b0, stim_rows[i].typed, stim_rows[i].res);
			endcase
		end

		phase = 0;
		while (sent_items < ITEM_TARGET) begin
			wait_quiet();
			no_idle = (phase == 4 || phase == 5);
			if (phase == 0) begin
				// one byte per frame so the queue fills behind the held receiver
				write_reg(REG_BITS_PER_SAMPLE, 6'd8);
				write_reg(REG_CHANNEL_COUNT, 6'd1);
				write_reg(REG_PAD_BYTES, 6'd0);
				hold_req = 1'b1;
			end else begin
				if ($urandom_range(0, 2) != 0) begin
					case ($urandom_range(0, 9))
						0: write_reg(REG_BITS_PER_SAMPLE, 6'd0);
						1: write_reg(REG_BITS_PER_SAMPLE, 6'd1);
						2: write_reg(REG_BITS_PER_SAMPLE, 6'd8);
						3: write_reg(REG_BITS_PER_SAMPLE, 6'd32);
						4: write_reg(REG_BITS_PER_SAMPLE, 6'd63);
						5: write_reg(REG_BITS_PER_SAMPLE, 6'd16);
						default: write_reg(REG_BITS_PER_SAMPLE, 6'($urandom_range(0, 63)));
					endcase
				end
				if ($urandom_range(0, 2) != 0) begin
					case ($urandom_range(0, 7))
						0: pick = 4'd0;
						1: pick = 4'd1;
						2: pick = 4'd8;
						3: pick = 4'd15;
						default: pick = 4'($urandom_range(0, 15));
					endcase
					write_reg(REG_CHANNEL_COUNT, {2'($urandom_range(0, 3)), pick});
				end
				if ($urandom_range(0, 2) != 0) begin
					kind = $urandom_range(0, 99);
					if (kind < 55)
						pick = 4'd0;
					else if (kind < 85)
						pick = 4'($urandom_range(1, 3));
					else if (kind < 92)
						pick = 4'd15;
					else
						pick = 4'($urandom_range(0, 15));
					write_reg(REG_PAD_BYTES, {2'($urandom_range(0, 3)), pick});
				end
			end

			frame_len = eff_chans() * (int'(cfg_pad) + (eff_bits() + 7) / 8);
			n_frames = $urandom_range(1, 1 + 150 / frame_len);
			if (phase == 0)
				n_frames = FILL_FRAMES;
			for (int f = 0; f < n_frames; f++) begin
				kind = $urandom_range(0, 99);
				if (kind < 84) begin
					repeat (frame_len) send_item(rand_byte(), 1'b0, 1'b0, none);
				end else if (kind < 93 && frame_len > 1) begin
					cut = $urandom_range(1, frame_len - 1);
					repeat (cut) send_item(rand_byte(), 1'b0, 1'b0, none);
					send_item(rand_byte(), 1'b1, 1'b0, none);
				end else begin
					send_item(rand_byte(), 1'b1, 1'b0, none);
				end
			end
			phase++;
		end

		wait_quiet();
		if (fails == 0 && mono_expected.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
